>>> hw/rtl/wsfp_pkg.sv
// Types and constants shared by the WebSocket frame parser files.
`timescale 1ns / 1ps

package wsfp_pkg;

   // Parser phase, one per header field plus payload and finished.
   typedef enum logic [2:0] {
      PH_OPCODE  = 3'd0,
      PH_LEN7    = 3'd1,
      PH_LEN16   = 3'd2,
      PH_LEN64   = 3'd3,
      PH_KEY     = 3'd4,
      PH_PAYLOAD = 3'd5,
      PH_DONE    = 3'd6
   } phase_type;

   // Result kinds.
   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_IGNORED = 2'd2;
   localparam logic [1:0] KIND_ERROR   = 2'd3;

   // Error codes.
   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_OPCODE = 2'd1;
   localparam logic [1:0] ERR_LENGTH = 2'd2;

   // Input actions.
   localparam logic ACT_BYTE   = 1'b0;
   localparam logic ACT_RESUME = 1'b1;

   // Opcodes that are legal on the wire.
   localparam logic [3:0] OP_CONT   = 4'h0;
   localparam logic [3:0] OP_TEXT   = 4'h1;
   localparam logic [3:0] OP_BINARY = 4'h2;
   localparam logic [3:0] OP_CLOSE  = 4'h8;
   localparam logic [3:0] OP_PING   = 4'h9;
   localparam logic [3:0] OP_PONG   = 4'hA;

   // Length escape codes in the 7-bit length field.
   localparam logic [6:0] LEN_ESC16 = 7'd126;
   localparam logic [6:0] LEN_ESC64 = 7'd127;

   // Header counts that close the 16-bit extended length and key fields.
   localparam logic [2:0] LEN16_BYTES = 3'd2;
   localparam logic [2:0] KEY_BYTES   = 3'd4;

   localparam logic [31:0] MAX_LEN_RESET = 32'd1024;

   typedef struct packed {
      logic       ctrl;
      logic       mask;
      logic       fin;
      logic [3:0] opcode;
   } frame_flags_type;

   typedef struct packed {
      logic       action;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] payload_byte;
      logic [3:0] opcode;
      logic       is_control;
      logic       fin;
      logic       frame_end;
      logic       message_end;
      logic [1:0] error_code;
   } rsp_type;

endpackage

>>> hw/rtl/wsfp_stream_if.sv
// Valid/ready stream interface carrying one payload beat.
`timescale 1ns / 1ps

interface wsfp_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

>>> hw/rtl/wsfp_parse_core.sv
// Frame parser state and per-beat next-state / result logic.
`timescale 1ns / 1ps

module wsfp_parse_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             step_valid,
   input  wsfp_pkg::req_type step_req,
   input  logic [31:0]      max_len,
   output wsfp_pkg::rsp_type step_rsp
);
   import wsfp_pkg::*;

   phase_type       phase_ff, phase_in;
   logic [2:0]      hcount_ff, hcount_in;
   frame_flags_type flags_ff, flags_in;
   logic [31:0]     len_ff, len_in;     // length, then bytes left in payload
   logic            ovf_ff, ovf_in;     // bits shifted out above 32
   logic [1:0]      pos_ff, pos_in;
   logic [7:0]      key_ff [4];
   logic            key_we;

   logic [7:0]  b;
   logic [2:0]  hcount_inc;
   logic        len_check;
   logic        start;
   logic [31:0] len_val;
   logic        ovf_val;
   logic        frame_done;
   logic [1:0]  kind;
   logic [7:0]  out_byte;
   logic        err_fe;
   logic        err_me;
   logic [1:0]  err_code;

   assign b          = step_req.data_byte;
   assign hcount_inc = hcount_ff + 3'd1;

   always_comb begin
      phase_in   = phase_ff;
      hcount_in  = hcount_ff;
      flags_in   = flags_ff;
      len_in     = len_ff;
      ovf_in     = ovf_ff;
      pos_in     = pos_ff;
      key_we     = 1'b0;
      len_check  = 1'b0;
      start      = 1'b0;
      len_val    = len_ff;
      ovf_val    = ovf_ff;
      frame_done = 1'b0;
      kind       = KIND_HEADER;
      out_byte   = 8'd0;
      err_fe     = 1'b0;
      err_me     = 1'b0;
      err_code   = ERR_NONE;

      if (step_req.action == ACT_RESUME) begin
         phase_in  = PH_OPCODE;
         hcount_in = 3'd0;
      end else begin
         case (phase_ff)
            PH_OPCODE: begin
               flags_in.opcode = b[3:0];
               flags_in.fin    = b[7];
               flags_in.mask   = 1'b0;
               flags_in.ctrl   = (b[3:0] inside {OP_CLOSE, OP_PING, OP_PONG});
               if (b[3:0] inside {OP_CONT, OP_TEXT, OP_BINARY,
                                  OP_CLOSE, OP_PING, OP_PONG}) begin
                  phase_in  = PH_LEN7;
                  hcount_in = 3'd0;
                  len_in    = 32'd0;
                  ovf_in    = 1'b0;
               end else begin
                  phase_in = PH_DONE;
                  kind     = KIND_ERROR;
                  err_code = ERR_OPCODE;
               end
            end
            PH_LEN7: begin
               flags_in.mask = flags_ff.mask | b[7];
               hcount_in     = 3'd0;
               len_in        = 32'd0;
               ovf_in        = 1'b0;
               if (b[6:0] == LEN_ESC16) begin
                  phase_in = PH_LEN16;
               end else if (b[6:0] == LEN_ESC64) begin
                  phase_in = PH_LEN64;
               end else begin
                  len_check = 1'b1;
                  len_val   = {25'd0, b[6:0]};
                  ovf_val   = 1'b0;
               end
            end
            PH_LEN16, PH_LEN64: begin
               len_val   = {len_ff[23:0], b};
               ovf_val   = ovf_ff | (len_ff[31:24] != 8'd0);
               len_in    = len_val;
               ovf_in    = ovf_val;
               hcount_in = hcount_inc;
               if ((phase_ff == PH_LEN16 && hcount_inc >= LEN16_BYTES) ||
                   (phase_ff == PH_LEN64 && hcount_inc == 3'd0)) begin
                  len_check = 1'b1;
               end
            end
            PH_KEY: begin
               key_we    = 1'b1;
               hcount_in = hcount_inc;
               if (hcount_inc >= KEY_BYTES) begin
                  start = 1'b1;
               end
            end
            PH_PAYLOAD: begin
               kind     = KIND_PAYLOAD;
               out_byte = flags_ff.mask ? (b ^ key_ff[pos_ff]) : b;
               pos_in   = pos_ff + 2'd1;
               len_in   = len_ff - 32'd1;
               if (len_ff == 32'd1) begin
                  frame_done = 1'b1;
               end
            end
            default: begin
               kind = KIND_IGNORED;
            end
         endcase

         // Length known: check against the limit, then key or payload.
         if (len_check) begin
            hcount_in = 3'd0;
            len_in    = len_val;
            ovf_in    = ovf_val;
            if (ovf_val || (len_val > max_len)) begin
               phase_in = PH_DONE;
               kind     = KIND_ERROR;
               err_code = ERR_LENGTH;
            end else if (flags_in.mask) begin
               phase_in = PH_KEY;
            end else begin
               start = 1'b1;
            end
         end

         // Header complete: enter payload or end an empty frame.
         if (start) begin
            hcount_in = 3'd0;
            pos_in    = 2'd0;
            if (len_val == 32'd0) begin
               frame_done = 1'b1;
            end else begin
               phase_in = PH_PAYLOAD;
            end
         end

         if (frame_done) begin
            err_fe = 1'b1;
            if (flags_in.ctrl || flags_in.fin) begin
               err_me   = 1'b1;
               phase_in = PH_DONE;
            end else begin
               phase_in = PH_OPCODE;
            end
         end
      end

      step_rsp.kind         = kind;
      step_rsp.payload_byte = out_byte;
      step_rsp.opcode       = flags_in.opcode;
      step_rsp.is_control   = flags_in.ctrl;
      step_rsp.fin          = flags_in.fin;
      step_rsp.frame_end    = err_fe;
      step_rsp.message_end  = err_me;
      step_rsp.error_code   = err_code;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_OPCODE;
         hcount_ff <= 3'd0;
         flags_ff  <= '0;
      end else if (step_valid) begin
         phase_ff  <= phase_in;
         hcount_ff <= hcount_in;
         flags_ff  <= flags_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_valid) begin
         len_ff <= len_in;
         ovf_ff <= ovf_in;
         pos_ff <= pos_in;
         if (key_we) begin
            key_ff[hcount_ff[1:0]] <= b;
         end
      end
   end

   a_payload_nonempty : assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> len_ff != 32'd0)
      else $error("payload phase with no bytes left");

   a_key_count : assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_KEY |-> hcount_ff < KEY_BYTES)
      else $error("key byte count out of range");

   a_len_in_range : assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> (!ovf_ff && len_ff <= max_len) || $past(step_valid))
      else $error("payload length left exceeds the limit");

endmodule

>>> hw/rtl/websocket_frame_parser.sv
// Top level of the WebSocket (RFC 6455) receive-side frame parser.
`timescale 1ns / 1ps

// Usage
//   req_bus  : sink beats of {action, data_byte}. action 0 carries one
//              received byte, action 1 resumes parsing at the opcode byte.
//   rsp_bus  : source beats of one result per request beat: kind, unmasked
//              payload byte, current opcode / control / FIN flags, frame end,
//              message end and error code.
//   csr_*    : write of max_payload_length (reset 1024); write only while idle.
// A request beat's result is registered and shows on rsp_bus in the cycle after
// the beat is accepted. Throughput is one beat per cycle while the receiver
// takes results, set by the single result register; header, length and unmask
// logic all fit between the parser state and that register.
// Reset clears the parser to the opcode-byte phase with all frame flags zero
// and empties the result register.
// When the receiver stalls, hold the result and drop req_bus.ready until the
// result beat is taken; ready returns in the same cycle the result drains.
// After a message end or an error, bytes return kind "ignored" until a
// resume beat arrives.
module websocket_frame_parser (
   input  logic        clock,
   input  logic        reset,
   wsfp_stream_if.sink   req_bus,
   wsfp_stream_if.source rsp_bus,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);
   import wsfp_pkg::*;

   logic        req_accept;
   logic [31:0] max_len_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_data_ff;
   rsp_type     step_rsp;
   req_type     req_beat;

   assign req_beat = req_bus.payload;

   // Take a new beat whenever the result register is empty or draining.
   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign req_accept    = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_write_enable) begin
         max_len_ff <= csr_write_data;
      end
   end

   wsfp_parse_core u_core (
      .clock      (clock),
      .reset      (reset),
      .step_valid (req_accept),
      .step_req   (req_beat),
      .max_len    (max_len_ff),
      .step_rsp   (step_rsp)
   );

   // Result register: load on accept, clear once taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_data_ff;

   a_resume_result : assert property (@(posedge clock) disable iff (reset)
      req_accept && req_beat.action == ACT_RESUME |=>
         rsp_bus.valid && rsp_bus.payload.kind == KIND_HEADER &&
         !rsp_bus.payload.frame_end && !rsp_bus.payload.message_end &&
         rsp_bus.payload.error_code == ERR_NONE)
      else $error("resume beat gave a wrong result");

   a_msg_end_frame : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && rsp_bus.payload.message_end |-> rsp_bus.payload.frame_end)
      else $error("message end without frame end");

   a_error_code : assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |->
         (rsp_bus.payload.kind == KIND_ERROR) ==
         (rsp_bus.payload.error_code != ERR_NONE))
      else $error("error kind and error code disagree");

endmodule

>>> tb/websocket_frame_parser_tb.sv
// Self-checking testbench for the WebSocket frame parser: random frames against a predictor.
`timescale 1ns / 1ps

module websocket_frame_parser_tb;
   import wsfp_pkg::*;

   logic        clock;
   logic        reset;
   logic        csr_write_enable;
   logic [31:0] csr_write_data;

   wsfp_stream_if #(.payload_type(req_type)) req_chan ();
   wsfp_stream_if #(.payload_type(rsp_type)) rsp_chan ();

   websocket_frame_parser uut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_chan),
      .rsp_bus          (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // Parser state as the predictor tracks it, plus its copy of the length limit.
   phase_type       parse_phase;
   logic [2:0]      header_count;
   frame_flags_type flags;
   logic [63:0]     frame_length;
   logic [63:0]     frame_position;
   logic [7:0]      mask_key [4];
   logic [31:0]     length_limit;

   req_type     byte_queue [$];    // beats waiting for the driver
   rsp_type     result_queue [$];  // predicted results, oldest first
   int unsigned beats_queued;
   int unsigned mismatch_count;
   int unsigned send_gap;
   int unsigned recv_stall;
   bit          send_idle;
   bit          recv_idle;
   bit          req_fired;

   // Free-running clock, 10 ns period.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop in case the block hangs; the slowest legal run is far shorter.
   initial begin
      #50_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic bit is_control_op(logic [3:0] opcode);
      return opcode == OP_CLOSE || opcode == OP_PING || opcode == OP_PONG;
   endfunction

   // Frame complete: go to finished on a control or final frame, which also
   // ends the message; otherwise wait for the next opcode byte.
   function automatic bit close_frame();
      if (flags.ctrl || flags.fin) begin
         parse_phase = PH_DONE;
         return 1'b1;
      end
      parse_phase = PH_OPCODE;
      return 1'b0;
   endfunction

   // Header finished: an empty frame ends right here on its last header byte.
   function automatic void open_payload(output logic fe, output logic me);
      header_count   = '0;
      frame_position = '0;
      fe = 1'b0;
      me = 1'b0;
      if (frame_length == '0) begin
         fe = 1'b1;
         me = close_frame();
      end else begin
         parse_phase = PH_PAYLOAD;
      end
   endfunction

   // Length known: check it against the limit whatever its encoding, then
   // go on to the key or straight into the payload.
   function automatic void check_length(output logic [1:0] kind, output logic [1:0] err,
                                        output logic fe, output logic me);
      header_count = '0;
      kind = KIND_HEADER;
      err  = ERR_NONE;
      fe   = 1'b0;
      me   = 1'b0;
      if (frame_length > {32'd0, length_limit}) begin
         parse_phase = PH_DONE;
         kind = KIND_ERROR;
         err  = ERR_LENGTH;
      end else if (flags.mask) begin
         parse_phase = PH_KEY;
      end else begin
         open_payload(fe, me);
      end
   endfunction

   // Advance the predicted parser by one accepted beat and return its result.
   function automatic rsp_type parse_step(req_type beat);
      rsp_type    res;
      logic [7:0] b;
      logic [7:0] out_byte;
      logic [1:0] kind;
      logic [1:0] err;
      logic       fe;
      logic       me;
      b        = beat.data_byte;
      out_byte = '0;
      kind     = KIND_HEADER;
      err      = ERR_NONE;
      fe       = 1'b0;
      me       = 1'b0;
      if (beat.action == ACT_RESUME) begin
         parse_phase  = PH_OPCODE;
         header_count = '0;
      end else begin
         case (parse_phase)
            PH_OPCODE: begin
               // Reserved bits are dropped; the flags hold even a bad opcode.
               flags        = '0;
               flags.opcode = b[3:0];
               flags.fin    = b[7];
               flags.ctrl   = is_control_op(b[3:0]);
               if (!(flags.ctrl || b[3:0] == OP_CONT || b[3:0] == OP_TEXT ||
                     b[3:0] == OP_BINARY)) begin
                  parse_phase = PH_DONE;
                  kind = KIND_ERROR;
                  err  = ERR_OPCODE;
               end else begin
                  frame_length   = '0;
                  frame_position = '0;
                  header_count   = '0;
                  parse_phase    = PH_LEN7;
               end
            end
            PH_LEN7: begin
               if (b[7]) begin
                  flags.mask = 1'b1;
               end
               header_count = '0;
               frame_length = '0;
               if (b[6:0] == LEN_ESC16) begin
                  parse_phase = PH_LEN16;
               end else if (b[6:0] == LEN_ESC64) begin
                  parse_phase = PH_LEN64;
               end else begin
                  frame_length = {57'd0, b[6:0]};
                  check_length(kind, err, fe, me);
               end
            end
            PH_LEN16, PH_LEN64: begin
               // Big-endian; the 64-bit form closes when the 3-bit count wraps.
               frame_length = {frame_length[55:0], b};
               header_count = header_count + 3'd1;
               if ((parse_phase == PH_LEN16 && header_count >= LEN16_BYTES) ||
                   (parse_phase == PH_LEN64 && header_count == 3'd0)) begin
                  check_length(kind, err, fe, me);
               end
            end
            PH_KEY: begin
               mask_key[header_count[1:0]] = b;
               header_count = header_count + 3'd1;
               if (header_count >= KEY_BYTES) begin
                  open_payload(fe, me);
               end
            end
            PH_PAYLOAD: begin
               out_byte = flags.mask ? (b ^ mask_key[frame_position[1:0]]) : b;
               frame_position = frame_position + 64'd1;
               kind = KIND_PAYLOAD;
               if (frame_position == frame_length) begin
                  fe = 1'b1;
                  me = close_frame();
               end
            end
            default: begin
               // Finished: ignore the byte and change nothing.
               kind = KIND_IGNORED;
            end
         endcase
      end
      res.kind         = kind;
      res.payload_byte = out_byte;
      res.opcode       = flags.opcode;
      res.is_control   = flags.ctrl;
      res.fin          = flags.fin;
      res.frame_end    = fe;
      res.message_end  = me;
      res.error_code   = err;
      return res;
   endfunction

   // Gap length for either side: mostly none or short, now and then long.
   function automatic int unsigned next_gap(bit enabled);
      int unsigned pick;
      if (!enabled) begin
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         return 0;
      end else if (pick < 92) begin
         return $urandom_range(1, 3);
      end else if (pick < 99) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(20, 60);
   endfunction

   // Queue one beat; ignored noise bytes are not counted as traffic.
   task automatic queue_beat(logic action, logic [7:0] data, bit counted);
      req_type beat;
      beat.action    = action;
      beat.data_byte = data;
      byte_queue.push_back(beat);
      if (counted) begin
         beats_queued++;
      end
   endtask

   // Queue one frame. form: 0 = 7-bit, 1 = 16-bit, 2 = 64-bit length.
   // A nonzero cut truncates the frame to at most cut bytes, never whole.
   // An over-limit frame stops after its length, as the block does.
   task automatic queue_frame(logic fin, logic [3:0] opcode, logic masked,
                              logic [63:0] length, int unsigned form, int unsigned cut);
      logic [7:0]  frame [$];
      logic [7:0]  key_bytes [4];
      logic [2:0]  rsv;
      int unsigned count;
      rsv = 3'($urandom_range(0, 7));
      foreach (key_bytes[i]) begin
         key_bytes[i] = 8'($urandom_range(0, 255));
      end
      frame.push_back({fin, rsv, opcode});
      if (form == 0) begin
         frame.push_back({masked, length[6:0]});
      end else if (form == 1) begin
         frame.push_back({masked, LEN_ESC16});
         frame.push_back(length[15:8]);
         frame.push_back(length[7:0]);
      end else begin
         frame.push_back({masked, LEN_ESC64});
         for (int i = 7; i >= 0; i--) begin
            frame.push_back(length[8*i +: 8]);
         end
      end
      if (length <= {32'd0, length_limit}) begin
         if (masked) begin
            foreach (key_bytes[i]) begin
               frame.push_back(key_bytes[i]);
            end
         end
         for (int unsigned i = 0; i < length; i++) begin
            frame.push_back(8'($urandom_range(0, 255)));
         end
      end
      count = frame.size();
      if (cut != 0) begin
         count = (cut < frame.size()) ? cut : frame.size() - 1;
      end
      for (int unsigned i = 0; i < count; i++) begin
         queue_beat(ACT_BYTE, frame[i], 1'b1);
      end
   endtask

   // Random traffic: mostly well-formed frames with random content, the
   // rest truncated frames, bad opcodes and raw noise, each followed by a resume.
   task automatic queue_random_traffic(int unsigned count);
      int unsigned goal;
      int unsigned pick;
      int unsigned form;
      int unsigned cut;
      logic [63:0] length;
      logic [3:0]  opcode;
      logic [7:0]  data;
      logic        fin;
      logic        masked;
      goal = beats_queued + count;
      while (beats_queued < goal) begin
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            case ($urandom_range(0, 9))
               0, 1, 2: opcode = OP_CONT;
               3, 4:    opcode = OP_TEXT;
               5, 6:    opcode = OP_BINARY;
               7:       opcode = OP_CLOSE;
               8:       opcode = OP_PING;
               default: opcode = OP_PONG;
            endcase
            fin    = 1'($urandom_range(0, 1));
            masked = $urandom_range(0, 2) != 0;
            cut    = (pick < 70) ? 0 : $urandom_range(1, 14);
            pick   = $urandom_range(0, 99);
            if (pick < 45) begin
               length = 64'($urandom_range(0, 8));
            end else if (pick < 75) begin
               length = 64'($urandom_range(9, 40));
            end else if (pick < 85) begin
               length = 64'($urandom_range(41, 140));
            end else if (pick < 88) begin
               length = 64'($urandom_range(141, 300));
            end else if (pick < 96 && length_limit < 300) begin
               // Right at the limit or one over it.
               length = 64'(length_limit) + 64'($urandom_range(0, 1));
            end else begin
               // Upper word set: always over the limit.
               length = {$urandom | 32'd1, $urandom};
            end
            if (length < 126) begin
               form = ($urandom_range(0, 5) < 4) ? 0 : $urandom_range(1, 2);
            end else if (length < 65536) begin
               form = $urandom_range(1, 2);
            end else begin
               form = 2;
            end
            queue_frame(fin, opcode, masked, length, form, cut);
            if (cut != 0 || fin || is_control_op(opcode) || length > {32'd0, length_limit}) begin
               if (cut == 0) begin
                  repeat ($urandom_range(0, 2)) begin
                     queue_beat(ACT_BYTE, 8'($urandom_range(0, 255)), 1'b0);
                  end
               end
               queue_beat(ACT_RESUME, 8'($urandom_range(0, 255)), 1'b1);
            end
         end else if (pick < 90) begin
            // Opcodes 3-7 and 11-15.
            opcode = 4'($urandom_range(3, 12));
            if (opcode > 7) begin
               opcode = opcode + 4'd3;
            end
            data = 8'($urandom_range(0, 255));
            data[3:0] = opcode;
            queue_beat(ACT_BYTE, data, 1'b1);
            repeat ($urandom_range(0, 3)) begin
               queue_beat(ACT_BYTE, 8'($urandom_range(0, 255)), 1'b0);
            end
            queue_beat(ACT_RESUME, 8'($urandom_range(0, 255)), 1'b1);
         end else begin
            // Raw bytes from the opcode phase; none at all can give a double resume.
            repeat ($urandom_range(0, 4)) begin
               queue_beat(ACT_BYTE, 8'($urandom_range(0, 255)), 1'b1);
            end
            queue_beat(ACT_RESUME, 8'($urandom_range(0, 255)), 1'b1);
         end
      end
   endtask

   // Hold until every queued beat is sent and every result has come back.
   task automatic wait_for_drain();
      do begin
         @(posedge clock);
         #1;
      end while (byte_queue.size() != 0 || req_chan.valid || result_queue.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   // Write the length limit while the block is idle; the predictor follows.
   task automatic write_length_limit(logic [31:0] value);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      length_limit = value;
   endtask

   task automatic check_field(string field, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         mismatch_count++;
      end
   endtask

   // Driver: advance to the next beat once the current one is taken, with
   // random gaps in between. Valid is assigned at most once per falling edge.
   always @(negedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
         send_gap       <= 0;
      end else if (!req_chan.valid || req_fired) begin
         if (send_gap != 0) begin
            req_chan.valid <= 1'b0;
            send_gap       <= send_gap - 1;
         end else if (byte_queue.size() != 0) begin
            req_chan.payload <= byte_queue.pop_front();
            req_chan.valid   <= 1'b1;
            send_gap         <= next_gap(send_idle);
         end else begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // Receiver: stall the result channel at random.
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         recv_stall     <= 0;
      end else if (recv_stall != 0) begin
         rsp_chan.ready <= 1'b0;
         recv_stall     <= recv_stall - 1;
      end else begin
         rsp_chan.ready <= 1'b1;
         recv_stall     <= next_gap(recv_idle);
      end
   end

   // Monitor: check each result beat against the oldest prediction, then
   // predict for a request beat taken at this edge.
   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         req_fired <= 1'b0;
      end else begin
         req_fired <= req_chan.valid && req_chan.ready;
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (result_queue.size() == 0) begin
               $display("%0t: unexpected result beat, expected none, actual %h",
                        $time, rsp_chan.payload);
               mismatch_count++;
            end else begin
               want = result_queue.pop_front();
               check_field("kind", want.kind, rsp_chan.payload.kind);
               check_field("payload_byte", want.payload_byte, rsp_chan.payload.payload_byte);
               check_field("opcode", want.opcode, rsp_chan.payload.opcode);
               check_field("is_control", want.is_control, rsp_chan.payload.is_control);
               check_field("fin", want.fin, rsp_chan.payload.fin);
               check_field("frame_end", want.frame_end, rsp_chan.payload.frame_end);
               check_field("message_end", want.message_end, rsp_chan.payload.message_end);
               check_field("error_code", want.error_code, rsp_chan.payload.error_code);
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            result_queue.push_back(parse_step(req_chan.payload));
         end
      end
   end

   // Stimulus: phases with different limits and idle patterns. Each phase
   // boundary pauses the sender until every expected result has come.
   initial begin
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_write_data   = '0;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
      parse_phase      = PH_OPCODE;
      header_count     = '0;
      flags            = '0;
      frame_length     = '0;
      frame_position   = '0;
      foreach (mask_key[i]) begin
         mask_key[i] = '0;
      end
      length_limit     = MAX_LEN_RESET;
      beats_queued     = 0;
      mismatch_count   = 0;
      send_idle        = 1'b1;
      recv_idle        = 1'b1;

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset limit, both sides idling.
      queue_beat(ACT_RESUME, 8'h00, 1'b1);                // resume straight out of reset
      queue_frame(1'b1, OP_TEXT, 1'b0, 64'd0, 0, 0);      // empty frame ends on its header
      queue_beat(ACT_RESUME, 8'hFF, 1'b1);
      queue_frame(1'b0, OP_BINARY, 1'b1, 64'd2, 0, 0);    // masked first fragment
      queue_frame(1'b1, OP_CONT, 1'b0, 64'd1, 0, 0);      // final continuation
      queue_beat(ACT_RESUME, 8'h00, 1'b1);
      queue_beat(ACT_BYTE, 8'hF3, 1'b1);                  // bad opcode, reserved bits set
      queue_beat(ACT_BYTE, 8'h55, 1'b0);                  // ignored while finished
      queue_beat(ACT_RESUME, 8'hAA, 1'b1);
      queue_frame(1'b1, OP_BINARY, 1'b0, 64'd1025, 1, 0); // one over the limit, 16-bit
      queue_beat(ACT_RESUME, 8'h00, 1'b1);
      queue_random_traffic(240);
      wait_for_drain();

      // Zero limit: only empty frames pass. No idling at all.
      write_length_limit(32'd0);
      send_idle = 1'b0;
      recv_idle = 1'b0;
      queue_frame(1'b1, OP_CLOSE, 1'b1, 64'd0, 0, 0);     // masked empty control frame
      queue_beat(ACT_RESUME, 8'h00, 1'b1);
      queue_frame(1'b1, OP_PONG, 1'b0, 64'd1, 0, 0);      // one byte is already too long
      queue_beat(ACT_RESUME, 8'h00, 1'b1);
      queue_random_traffic(240);
      wait_for_drain();

      // Widest limit: only a 64-bit length with its upper word set fails.
      write_length_limit(32'hFFFF_FFFF);
      send_idle = 1'b1;
      recv_idle = 1'b0;
      queue_frame(1'b1, OP_BINARY, 1'b1, 64'h0000_0001_0000_0000, 2, 0);
      queue_beat(ACT_RESUME, 8'h00, 1'b1);
      queue_frame(1'b0, OP_PING, 1'b0, 64'd2, 2, 0);      // control frame ends without FIN
      queue_beat(ACT_RESUME, 8'h00, 1'b1);
      queue_random_traffic(240);
      wait_for_drain();

      write_length_limit(32'd5);
      send_idle = 1'b0;
      recv_idle = 1'b1;
      queue_random_traffic(240);
      wait_for_drain();

      write_length_limit($urandom_range(0, 300));
      send_idle = 1'b1;
      recv_idle = 1'b1;
      queue_random_traffic(240);
      wait_for_drain();

      if (mismatch_count == 0 && result_queue.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
